/* rtl/core/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// lsp_pkg
// shared constants, config types and helpers for the location section parser
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int MAX_WANTED_DEFAULT  = 4;
	localparam int QUEUE_DEPTH_DEFAULT = 2;
	localparam int NUM_IDS             = 4;
	localparam int ID_W                = 16;
	localparam int OFFSET_W            = 32;
	localparam int COUNT_W             = 3;
	localparam int CFG_INDEX_W         = 3;
	localparam int CFG_DATA_W          = 16;
	localparam int HEADER_LEN          = 14;
	localparam int RECORD_LEN          = 10;

	localparam logic [OFFSET_W-1:0] NOT_FOUND = '1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_ID_0  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_ID_3  = 3'd4;

	typedef struct packed {
		logic [COUNT_W-1:0]              wanted_count;
		logic [NUM_IDS-1:0][ID_W-1:0]    wanted_id;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// number of table entries actually built
	function automatic int entry_limit(input int max_wanted);
		return (max_wanted < NUM_IDS) ? max_wanted : NUM_IDS;
	endfunction

	// index width for a table of the given size
	function automatic int index_width(input int entries);
		return (entries > 1) ? $clog2(entries) : 1;
	endfunction

endpackage

/* rtl/core/lsp_if.sv */
// ----------------------------------------------------------------------------
// lsp_if
// valid/ready stream interfaces for section bytes and report results
// ----------------------------------------------------------------------------
interface lsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       section_start;

	modport source (output valid, output data_byte, output section_start, input ready);
	modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface lsp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  entry_index;
	logic [31:0] component_offset;
	logic        last_of_run;

	modport source (output valid, output entry_index, output component_offset,
		output last_of_run, input ready);
	modport sink   (input valid, input entry_index, input component_offset,
		input last_of_run, output ready);
endinterface

/* rtl/core/lsp_front.sv */
// ----------------------------------------------------------------------------
// lsp_front
// byte parser: header count, record fields, id match and offset table
// ----------------------------------------------------------------------------
module lsp_front #(
	parameter int MAX_WANTED = lsp_pkg::MAX_WANTED_DEFAULT,
	parameter int REPORT_W   = lsp_pkg::COUNT_W
		+ lsp_pkg::entry_limit(MAX_WANTED) * lsp_pkg::OFFSET_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 section_start,
	input  lsp_pkg::cfg_t        cfg,
	output logic                 push,
	output logic [REPORT_W-1:0]  push_data
);
	import lsp_pkg::*;

	localparam int ENTRIES = entry_limit(MAX_WANTED);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_RECORDS = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	logic [1:0]                          phase_q, phase_d;
	logic [3:0]                          pos_q, pos_d;
	logic [15:0]                         total_q, total_d;
	logic [15:0]                         seen_q, seen_d;
	logic [ID_W-1:0]                     id_q, id_d;
	logic [OFFSET_W-1:0]                 off_q, off_d;
	logic [ENTRIES-1:0][OFFSET_W-1:0]    table_q, table_d;
	logic                                report;
	logic [COUNT_W-1:0]                  n_use;

	// wanted count clipped to the built table
	assign n_use = (cfg.wanted_count > COUNT_W'(ENTRIES)) ? COUNT_W'(ENTRIES)
		: cfg.wanted_count;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		total_d = total_q;
		seen_d  = seen_q;
		id_d    = id_q;
		off_d   = off_q;
		table_d = table_q;
		report  = 1'b0;
		if (section_start) begin
			phase_d = PH_HEADER;
			pos_d   = '0;
			total_d = '0;
			seen_d  = '0;
			id_d    = '0;
			off_d   = '0;
			for (int k = 0; k < ENTRIES; k++) table_d[k] = NOT_FOUND;
		end
		priority if (phase_d == PH_HEADER) begin
			if (pos_d == 4'd6 || pos_d == 4'd7) total_d = {total_d[7:0], data_byte};
			if (pos_d >= 4'(HEADER_LEN - 1)) begin
				pos_d = '0;
				if (total_d == '0) begin
					phase_d = PH_DONE;
					report  = 1'b1;
				end else begin
					phase_d = PH_RECORDS;
				end
			end else begin
				pos_d = pos_d + 4'd1;
			end
		end else if (phase_d == PH_RECORDS) begin
			if (pos_d < 4'd2) id_d = {id_d[7:0], data_byte};
			else if (pos_d >= 4'd6) off_d = {off_d[23:0], data_byte};
			if (pos_d >= 4'(RECORD_LEN - 1)) begin
				for (int k = 0; k < ENTRIES; k++) begin
					if (COUNT_W'(k) < n_use && cfg.wanted_id[k] == id_d) table_d[k] = off_d;
				end
				seen_d = seen_d + 16'd1;
				pos_d  = '0;
				if (seen_d == total_d) begin
					phase_d = PH_DONE;
					report  = 1'b1;
				end
			end else begin
				pos_d = pos_d + 4'd1;
			end
		end else begin
			// idle or done: byte dropped
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			total_q <= '0;
			seen_q  <= '0;
			id_q    <= '0;
			off_q   <= '0;
			for (int k = 0; k < ENTRIES; k++) table_q[k] <= NOT_FOUND;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			total_q <= total_d;
			seen_q  <= seen_d;
			id_q    <= id_d;
			off_q   <= off_d;
			table_q <= table_d;
		end
	end

	// an empty report has no results and is not queued
	assign push      = accept && report && (n_use != '0);
	assign push_data = {n_use, table_d};

endmodule

/* rtl/core/lsp_queue.sv */
// ----------------------------------------------------------------------------
// lsp_queue
// small fifo of report snapshots between parser and result emitter
// ----------------------------------------------------------------------------
module lsp_queue #(
	parameter int DEPTH = lsp_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head,
	output lsp_pkg::queue_stat_t stat
);
	import lsp_pkg::*;

	localparam int PTR_W = index_width(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/lsp_back.sv */
// ----------------------------------------------------------------------------
// lsp_back
// result emitter: walks one report snapshot, one entry per transfer
// ----------------------------------------------------------------------------
module lsp_back #(
	parameter int MAX_WANTED = lsp_pkg::MAX_WANTED_DEFAULT,
	parameter int REPORT_W   = lsp_pkg::COUNT_W
		+ lsp_pkg::entry_limit(MAX_WANTED) * lsp_pkg::OFFSET_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [REPORT_W-1:0]  head,
	input  lsp_pkg::queue_stat_t stat,
	output logic                 pop,
	lsp_result_if.source         results
);
	import lsp_pkg::*;

	localparam int ENTRIES = entry_limit(MAX_WANTED);
	localparam int K_W     = index_width(ENTRIES);

	logic                              busy_q;
	logic [COUNT_W-1:0]                n_q;
	logic [ENTRIES-1:0][OFFSET_W-1:0]  offs_q;
	logic [K_W-1:0]                    k_q;
	logic                              last, xfer;

	assign last = (COUNT_W'(k_q) + COUNT_W'(1)) == n_q;
	assign xfer = results.valid && results.ready;
	assign pop  = !stat.empty && (!busy_q || (xfer && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (xfer) begin
			if (last) busy_q <= 1'b0;
			else k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q    <= head[REPORT_W-1 -: COUNT_W];
			offs_q <= head[ENTRIES*OFFSET_W-1:0];
		end
	end

	assign results.valid            = busy_q;
	assign results.entry_index      = 2'(k_q);
	assign results.component_offset = offs_q[k_q];
	assign results.last_of_run      = last;

endmodule

/* rtl/core/location_section_parser.sv */
// ----------------------------------------------------------------------------
// location_section_parser
// parses a location section byte stream and reports the file offsets of
// up to four wanted component ids
// ----------------------------------------------------------------------------
//  channel   dir   transfer moves                                   width
//  bytes     in    data_byte, section_start                         8+1
//  results   out   entry_index, component_offset, last_of_run       2+32+1
//  cfg       in    cfg_we / cfg_index / cfg_data, write only        1+3+16
//
//  one byte per cycle unless stalled, one lsp_front parser step per byte
//  a report of n entries gives n result transfers, one entry per transfer
//  reports wait in a two-deep snapshot queue, so parsing goes on while
//  results drain; bytes stall only when that queue is full
//  reset clears all control state and sets the offset table to not found
// ----------------------------------------------------------------------------
module location_section_parser #(
	parameter int MAX_WANTED  = lsp_pkg::MAX_WANTED_DEFAULT,
	parameter int QUEUE_DEPTH = lsp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	lsp_byte_if.sink                          bytes,
	lsp_result_if.source                      results
);
	import lsp_pkg::*;

	// report snapshot: entry count on top, offset table below
	localparam int REPORT_W = COUNT_W + entry_limit(MAX_WANTED) * OFFSET_W;

	cfg_t                cfg_q;
	queue_stat_t         qstat;
	logic                accept;
	logic                push, pop;
	logic [REPORT_W-1:0] push_data, head;

	// config registers, writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			priority if (cfg_index == CFG_WANTED_COUNT) begin
				cfg_q.wanted_count <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index >= CFG_WANTED_ID_0 && cfg_index <= CFG_WANTED_ID_3) begin
				cfg_q.wanted_id[2'(cfg_index - CFG_WANTED_ID_0)] <= cfg_data[ID_W-1:0];
			end else begin
				cfg_q <= cfg_q;
			end
		end
	end

	// a byte is taken whenever a report could still be queued
	assign bytes.ready = !qstat.full;
	assign accept      = bytes.valid && bytes.ready;

	// front: parse, match, snapshot the table at report time
	lsp_front #(
		.MAX_WANTED (MAX_WANTED),
		.REPORT_W   (REPORT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (bytes.data_byte),
		.section_start (bytes.section_start),
		.cfg           (cfg_q),
		.push          (push),
		.push_data     (push_data)
	);

	// decoupling queue of pending reports
	lsp_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (REPORT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	// back: emit one result per wanted entry in use
	lsp_back #(
		.MAX_WANTED (MAX_WANTED),
		.REPORT_W   (REPORT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

/* rtl/core/lsp_checker.sv */
// ----------------------------------------------------------------------------
// lsp_checker
// port-level checks on the location section parser, bound to the top level
// ----------------------------------------------------------------------------
module lsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_index,
	input logic [31:0] res_offset,
	input logic        res_last
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_index)
			&& $stable(res_offset) && $stable(res_last))
		else $error("result changed while stalled");

	// entries of one report follow each other without gaps
	a_res_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid
			&& res_index == $past(res_index) + 2'd1)
		else $error("report entries out of sequence");

	// entry three is always the end of a report
	a_res_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_index == 2'd3 |-> res_last)
		else $error("report runs past its last entry");

	// byte side only stalls while results are pending
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> res_valid)
		else $error("byte stall with no result pending");

endmodule

bind location_section_parser lsp_checker u_lsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_ready (bytes.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_index  (results.entry_index),
	.res_offset (results.component_offset),
	.res_last   (results.last_of_run)
);
